/* rtl/ps_pkg.sv */
// ----------------------------------------------------------------------------
// ps_pkg
// Shared types and constants for the clamped-integral PID step block.
// ----------------------------------------------------------------------------
package ps_pkg;

	localparam int DATA_W   = 32;
	localparam int GAIN_W   = 32;
	localparam int LIM_W    = 31;
	localparam int ACC_W    = 48;
	localparam int IDX_W    = 3;
	localparam int FRAC_DEF = 16;
	localparam logic [LIM_W-1:0] LIM_RST = LIM_W'(65536);

	localparam logic CMD_STEP  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef enum logic [IDX_W-1:0] {
		REG_PROP   = 3'd0,
		REG_INTEG  = 3'd1,
		REG_DERIV  = 3'd2,
		REG_LIMIT  = 3'd3,
		REG_TARGET = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_MUL      = 2'd0,
		OP_DIV_LOAD = 2'd1,
		OP_DIV_KEEP = 2'd2
	} mdu_op_t;

	typedef struct packed {
		logic    start;
		mdu_op_t op;
	} mdu_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_P_GO,
		ST_P_WAIT,
		ST_E_GO,
		ST_E_WAIT,
		ST_B_GO,
		ST_B_WAIT,
		ST_I_GO,
		ST_I_WAIT,
		ST_DM_GO,
		ST_DM_WAIT,
		ST_DD_GO,
		ST_DD_WAIT,
		ST_SUM
	} state_t;

	typedef struct packed {
		logic                     command;
		logic signed [DATA_W-1:0] measurement;
		logic        [GAIN_W-1:0] time_step;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] drive;
		logic signed [DATA_W-1:0] prop_term;
		logic signed [DATA_W-1:0] integ_term;
		logic signed [DATA_W-1:0] deriv_term;
	} rsp_t;

endpackage

/* rtl/ps_mdu.sv */
// ----------------------------------------------------------------------------
// ps_mdu
// Bit-serial multiply (shift-add) and restoring divide sharing one register.
// ----------------------------------------------------------------------------
module ps_mdu #(
	parameter int A_W = 48,
	parameter int B_W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ps_pkg::mdu_ctl_t     ctl,
	input  logic [A_W-1:0]       a,
	input  logic [B_W-1:0]       b,
	input  logic [A_W+B_W-1:0]   din,
	output logic                 busy,
	output logic                 done,
	output logic [A_W+B_W-1:0]   res
);
	localparam int P_W   = A_W + B_W;
	localparam int CNT_W = $clog2(P_W);

	logic             busy_q;
	logic             done_q;
	logic             div_q;
	logic [CNT_W-1:0] cnt_q;
	logic [P_W-1:0]   prod_q;
	logic [B_W-1:0]   rem_q;

	logic [A_W:0]     mul_sum;
	logic [P_W-1:0]   mul_next;
	logic [B_W:0]     div_t;
	logic             div_ge;
	logic [B_W:0]     div_r;
	logic [P_W-1:0]   div_next;

	always_comb begin
		mul_sum  = {1'b0, prod_q[P_W-1:B_W]} + (prod_q[0] ? {1'b0, a} : '0);
		mul_next = {mul_sum, prod_q[B_W-1:1]};
		div_t    = {rem_q, prod_q[P_W-1]};
		div_ge   = div_t >= {1'b0, b};
		div_r    = div_ge ? (div_t - {1'b0, b}) : div_t;
		div_next = {prod_q[P_W-2:0], div_ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			div_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				div_q  <= ctl.op != ps_pkg::OP_MUL;
				cnt_q  <= (ctl.op == ps_pkg::OP_MUL) ? CNT_W'(B_W - 1) : CNT_W'(P_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			case (ctl.op)
				ps_pkg::OP_MUL:      prod_q <= {{A_W{1'b0}}, b};
				ps_pkg::OP_DIV_LOAD: prod_q <= din;
				default:             prod_q <= prod_q;
			endcase
		end else if (busy_q) begin
			if (div_q) begin
				prod_q <= div_next;
				rem_q  <= div_r[B_W-1:0];
			end else begin
				prod_q <= mul_next;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign res  = prod_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !busy_q) else $error("mdu started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("mdu done without work");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("mdu busy at done");

endmodule

/* rtl/pid_step_with_clamped_integral_top.sv */
// ----------------------------------------------------------------------------
// pid_step_with_clamped_integral_top
// PID step with derivative on measurement and clamped integral accumulator.
// ----------------------------------------------------------------------------
// sequence: a compute request runs 32-step multiplies and 80-step divides, then a
//   sum; bound divide skipped at zero integ_gain, derivative multiply and divide
//   skipped at zero time_step; a clear request goes straight to the sum state
// throughput: one request at a time, next one taken the cycle after the result loads
// the result register lets a new request start while the previous result waits
// reset: gains and target zero, limit 1.0, accumulator and history zero
module pid_step_with_clamped_integral_top #(
	parameter int FRAC_BITS = ps_pkg::FRAC_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  ps_pkg::req_t                req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output ps_pkg::rsp_t                rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ps_pkg::IDX_W-1:0]    cfg_index,
	input  logic [ps_pkg::GAIN_W-1:0]   cfg_data
);
	localparam int W  = ps_pkg::DATA_W;
	localparam int GW = ps_pkg::GAIN_W;
	localparam int AW = ps_pkg::ACC_W;
	localparam int MA = (W + 1 > AW) ? W + 1 : AW;
	localparam int PW = MA + GW;
	localparam logic [PW-1:0] TPOS = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic [PW-1:0] TNEG = TPOS + PW'(1);
	localparam logic [PW-1:0] APOS = {{(PW-AW+1){1'b0}}, {(AW-1){1'b1}}};
	localparam logic [PW-1:0] ANEG = APOS + PW'(1);

	ps_pkg::state_t state_q, state_d;

	logic [GW-1:0]                 kp_q, ki_q, kd_q;
	logic [ps_pkg::LIM_W-1:0]      lim_q;
	logic signed [W-1:0]           tgt_q;
	logic signed [AW-1:0]          accum_q;
	logic signed [W-1:0]           prev_q;
	logic signed [W:0]             err_q, diff_q;
	logic [GW-1:0]                 dt_q;
	logic signed [W-1:0]           p_q, i_q, d_q;
	ps_pkg::rsp_t                  rsp_q;
	logic                          rsp_valid_q;

	ps_pkg::mdu_ctl_t              mdu_ctl;
	logic [MA-1:0]                 mdu_a;
	logic [GW-1:0]                 mdu_b;
	logic [PW-1:0]                 mdu_din, mdu_res;
	logic                          mdu_busy, mdu_done;

	logic                          req_acc, rsp_load;
	logic                          err_neg, diff_pos, acc_neg;
	logic [W:0]                    err_mag, diff_mag;
	logic [AW-1:0]                 acc_mag;
	logic [PW-1:0]                 shifted;
	logic [PW-1:0]                 p_mag, e_mag, i_mag, d_mag, b_mag;
	logic signed [AW-1:0]          edt, bnd;
	logic signed [AW:0]            acc_sum;
	logic signed [AW-1:0]          acc_sat, acc_clamp;
	logic signed [W+1:0]           sum, lim_x;
	logic signed [W-1:0]           drive_v;

	function automatic logic [PW-1:0] sat_min(input logic [PW-1:0] v, input logic [PW-1:0] c);
		return (v > c) ? c : v;
	endfunction

	ps_mdu #(.A_W(MA), .B_W(GW)) u_mdu (
		.clk(clk), .arst_n(arst_n), .ctl(mdu_ctl), .a(mdu_a), .b(mdu_b),
		.din(mdu_din), .busy(mdu_busy), .done(mdu_done), .res(mdu_res)
	);

	assign cfg_ready = 1'b1;
	assign req_stall = state_q != ps_pkg::ST_IDLE;
	assign req_acc   = req_valid && !req_stall;
	assign rsp_load  = (state_q == ps_pkg::ST_SUM) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// datapath helpers
	always_comb begin
		err_neg  = err_q[W];
		err_mag  = err_neg ? (-err_q) : err_q;
		diff_pos = !diff_q[W] && (diff_q != '0);
		diff_mag = diff_q[W] ? (-diff_q) : diff_q;
		acc_neg  = accum_q[AW-1];
		acc_mag  = acc_neg ? (-accum_q) : accum_q;
		shifted  = mdu_res >> FRAC_BITS;

		p_mag = sat_min(shifted, err_neg ? TNEG : TPOS);
		e_mag = sat_min(shifted, err_neg ? ANEG : APOS);
		i_mag = sat_min(shifted, acc_neg ? TNEG : TPOS);
		d_mag = sat_min(mdu_res, diff_pos ? TNEG : TPOS);
		b_mag = sat_min(mdu_res, APOS);

		edt     = err_neg ? -$signed(e_mag[AW-1:0]) : $signed(e_mag[AW-1:0]);
		acc_sum = {accum_q[AW-1], accum_q} + {edt[AW-1], edt};
		if (acc_sum[AW] != acc_sum[AW-1])
			acc_sat = acc_sum[AW] ? $signed({1'b1, {(AW-1){1'b0}}})
				: $signed({1'b0, {(AW-1){1'b1}}});
		else
			acc_sat = acc_sum[AW-1:0];

		bnd = $signed(b_mag[AW-1:0]);
		if (accum_q > bnd)
			acc_clamp = bnd;
		else if (accum_q < -bnd)
			acc_clamp = -bnd;
		else
			acc_clamp = accum_q;

		sum   = {{2{p_q[W-1]}}, p_q} + {{2{i_q[W-1]}}, i_q} + {{2{d_q[W-1]}}, d_q};
		lim_x = $signed({{(W+2-ps_pkg::LIM_W){1'b0}}, lim_q});
		if (sum > lim_x)
			drive_v = lim_x[W-1:0];
		else if (sum < -lim_x)
			drive_v = W'(-lim_x);
		else
			drive_v = sum[W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ps_pkg::ST_IDLE: begin
				if (req_acc)
					state_d = (req.command == ps_pkg::CMD_CLEAR) ? ps_pkg::ST_SUM
						: ps_pkg::ST_P_GO;
			end
			ps_pkg::ST_P_GO:   state_d = ps_pkg::ST_P_WAIT;
			ps_pkg::ST_P_WAIT: if (mdu_done) state_d = ps_pkg::ST_E_GO;
			ps_pkg::ST_E_GO:   state_d = ps_pkg::ST_E_WAIT;
			ps_pkg::ST_E_WAIT: begin
				if (mdu_done)
					state_d = (ki_q != '0) ? ps_pkg::ST_B_GO : ps_pkg::ST_I_GO;
			end
			ps_pkg::ST_B_GO:   state_d = ps_pkg::ST_B_WAIT;
			ps_pkg::ST_B_WAIT: if (mdu_done) state_d = ps_pkg::ST_I_GO;
			ps_pkg::ST_I_GO:   state_d = ps_pkg::ST_I_WAIT;
			ps_pkg::ST_I_WAIT: begin
				if (mdu_done)
					state_d = (dt_q != '0) ? ps_pkg::ST_DM_GO : ps_pkg::ST_SUM;
			end
			ps_pkg::ST_DM_GO:   state_d = ps_pkg::ST_DM_WAIT;
			ps_pkg::ST_DM_WAIT: if (mdu_done) state_d = ps_pkg::ST_DD_GO;
			ps_pkg::ST_DD_GO:   state_d = ps_pkg::ST_DD_WAIT;
			ps_pkg::ST_DD_WAIT: if (mdu_done) state_d = ps_pkg::ST_SUM;
			ps_pkg::ST_SUM:     if (rsp_load) state_d = ps_pkg::ST_IDLE;
			default:            state_d = ps_pkg::ST_IDLE;
		endcase
	end

	// unit control
	always_comb begin
		mdu_ctl.start = 1'b0;
		mdu_ctl.op    = ps_pkg::OP_MUL;
		mdu_a         = '0;
		mdu_b         = '0;
		mdu_din       = PW'(lim_q) << FRAC_BITS;
		unique case (state_q)
			ps_pkg::ST_P_GO: begin
				mdu_ctl.start = 1'b1;
				mdu_a = MA'(err_mag);
				mdu_b = kp_q;
			end
			ps_pkg::ST_E_GO: begin
				mdu_ctl.start = 1'b1;
				mdu_a = MA'(err_mag);
				mdu_b = dt_q;
			end
			ps_pkg::ST_B_GO, ps_pkg::ST_B_WAIT: begin
				mdu_ctl.start = state_q == ps_pkg::ST_B_GO;
				mdu_ctl.op    = ps_pkg::OP_DIV_LOAD;
				mdu_b = ki_q;
			end
			ps_pkg::ST_I_GO: begin
				mdu_ctl.start = 1'b1;
				mdu_a = MA'(acc_mag);
				mdu_b = ki_q;
			end
			ps_pkg::ST_DM_GO, ps_pkg::ST_DM_WAIT: begin
				mdu_ctl.start = state_q == ps_pkg::ST_DM_GO;
				mdu_a = MA'(diff_mag);
				mdu_b = kd_q;
			end
			ps_pkg::ST_DD_GO, ps_pkg::ST_DD_WAIT: begin
				mdu_ctl.start = state_q == ps_pkg::ST_DD_GO;
				mdu_ctl.op    = ps_pkg::OP_DIV_KEEP;
				mdu_b = dt_q;
			end
			ps_pkg::ST_P_WAIT: begin
				mdu_a = MA'(err_mag);
				mdu_b = kp_q;
			end
			ps_pkg::ST_E_WAIT: begin
				mdu_a = MA'(err_mag);
				mdu_b = dt_q;
			end
			ps_pkg::ST_I_WAIT: begin
				mdu_a = MA'(acc_mag);
				mdu_b = ki_q;
			end
			default: begin
				mdu_ctl.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ps_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
			kp_q        <= '0;
			ki_q        <= '0;
			kd_q        <= '0;
			lim_q       <= ps_pkg::LIM_RST;
			tgt_q       <= '0;
			accum_q     <= '0;
			prev_q      <= '0;
		end else begin
			state_q <= state_d;
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				unique case (ps_pkg::reg_idx_t'(cfg_index))
					ps_pkg::REG_PROP:   kp_q <= cfg_data;
					ps_pkg::REG_INTEG:  ki_q <= cfg_data;
					ps_pkg::REG_DERIV:  kd_q <= cfg_data;
					ps_pkg::REG_LIMIT: begin
						if (cfg_data[ps_pkg::LIM_W-1:0] != '0)
							lim_q <= cfg_data[ps_pkg::LIM_W-1:0];
					end
					ps_pkg::REG_TARGET: tgt_q <= $signed(cfg_data[W-1:0]);
					default: ;
				endcase
			end

			if (req_acc) begin
				if (req.command == ps_pkg::CMD_CLEAR) begin
					accum_q <= '0;
					prev_q  <= '0;
				end else begin
					prev_q <= req.measurement;
				end
			end
			if (state_q == ps_pkg::ST_E_WAIT && mdu_done)
				accum_q <= acc_sat;
			if (state_q == ps_pkg::ST_B_WAIT && mdu_done)
				accum_q <= acc_clamp;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			err_q  <= {tgt_q[W-1], tgt_q} - {req.measurement[W-1], req.measurement};
			diff_q <= {req.measurement[W-1], req.measurement} - {prev_q[W-1], prev_q};
			dt_q   <= req.time_step;
			p_q    <= '0;
			i_q    <= '0;
			d_q    <= '0;
		end
		if (state_q == ps_pkg::ST_P_WAIT && mdu_done)
			p_q <= err_neg ? -$signed(p_mag[W-1:0]) : $signed(p_mag[W-1:0]);
		if (state_q == ps_pkg::ST_I_WAIT && mdu_done)
			i_q <= acc_neg ? -$signed(i_mag[W-1:0]) : $signed(i_mag[W-1:0]);
		if (state_q == ps_pkg::ST_DD_WAIT && mdu_done)
			d_q <= diff_pos ? -$signed(d_mag[W-1:0]) : $signed(d_mag[W-1:0]);
		if (rsp_load) begin
			rsp_q.drive      <= drive_v;
			rsp_q.prop_term  <= p_q;
			rsp_q.integ_term <= i_q;
			rsp_q.deriv_term <= d_q;
		end
	end

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |-> (state_q == ps_pkg::ST_IDLE && !mdu_busy))
		else $error("request taken while busy");
	a_rsp_from_sum: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ps_pkg::ST_SUM))
		else $error("result without sum state");
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.command == ps_pkg::CMD_CLEAR) |=> (accum_q == '0 && p_q == '0))
		else $error("clear left state");

endmodule
